@@ rtl/gbia_pkg.sv @@
// ----------------------------------------------------------------------------
// gbia_pkg
// Shared widths, codes and types of the grouped bitmap identifier allocator.
// ----------------------------------------------------------------------------
package gbia_pkg;

    localparam int ID_W     = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;
    localparam int WORD_W   = 32;
    localparam int WSH      = 5;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic           found;
        logic [WSH-1:0] bit_idx;
    } scan_res_t;

endpackage

@@ rtl/gbia_word_scan.sv @@
// ----------------------------------------------------------------------------
// gbia_word_scan
// Finds the lowest clear bit of one bitmap word that lies inside a group span.
// ----------------------------------------------------------------------------
module gbia_word_scan #(
    parameter int BW  = 20,
    parameter int WAW = 6
) (
    input  logic [gbia_pkg::WORD_W-1:0] word,
    input  logic [WAW-1:0]              waddr,
    input  logic [BW-1:0]               lo,
    input  logic [BW-1:0]               hi,
    output gbia_pkg::scan_res_t         res
);
    import gbia_pkg::*;

    logic [WORD_W-1:0] cand;

    always_comb begin
        logic [BW-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            pos     = BW'({waddr, WSH'(i)});
            cand[i] = ~word[i] && (pos >= lo) && (pos < hi);
        end
    end

    always_comb begin
        res.found   = |cand;
        res.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                res.bit_idx = WSH'(i);
            end
        end
    end

endmodule

@@ rtl/grouped_bitmap_id_allocator_top.sv @@
// ----------------------------------------------------------------------------
// grouped_bitmap_id_allocator_top
// Allocate: walks the group free counts, then scans the group's 32-bit bitmap words.
// Free: steps through the groups to the one that holds the id, then clears
// its bit if it is set. One request is worked on at a
// time; the next is taken the cycle after its result reaches the output
// register, which waits while an earlier result beat is still held there.
// The count and bitmap memories (one read port each) set the scan speed.
// After reset a clearing pass over max(map words, MAX_GROUPS) entries runs
// (64 at defaults) with s_ready low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module grouped_bitmap_id_allocator_top #(
    parameter int MAX_GROUPS    = 8,
    parameter int IDS_PER_GROUP = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gbia_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [gbia_pkg::ID_W-1:0]     s_free_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gbia_pkg::ID_W-1:0]     m_allocated_id,
    output logic [gbia_pkg::STATUS_W-1:0] m_status
);
    import gbia_pkg::*;

    localparam int TOTAL_IDS = MAX_GROUPS * IDS_PER_GROUP;
    localparam int MAP_WORDS = (TOTAL_IDS + WORD_W - 1) / WORD_W;
    localparam int BW_RAW    = $clog2(TOTAL_IDS + WORD_W + 1);
    localparam int BW        = (BW_RAW > ID_W) ? BW_RAW : ID_W;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int GW        = $clog2(MAX_GROUPS + 1);
    localparam int GIW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNW       = $clog2(IDS_PER_GROUP + 1);
    localparam int CLR_LEN   = (MAP_WORDS > MAX_GROUPS) ? MAP_WORDS : MAX_GROUPS;
    localparam int CLW       = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
    localparam int RGW       = (CFG_W > GW) ? CFG_W : GW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACNT  = 3'd2;
    localparam logic [2:0] S_AWORD = 3'd3;
    localparam logic [2:0] S_FGRP  = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    // memories
    logic [WORD_W-1:0] map_mem [MAP_WORDS];
    logic [CNW-1:0]    cnt_mem [MAX_GROUPS];

    logic [WORD_W-1:0] map_rd;
    logic [CNW-1:0]    cnt_rd;
    logic [WAW-1:0]    map_ra, map_wa;
    logic [GIW-1:0]    cnt_ra, cnt_wa;
    logic [WORD_W-1:0] map_wd;
    logic [CNW-1:0]    cnt_wd;
    logic              map_we, cnt_we;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd <= map_mem[map_ra];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    // control and datapath registers
    logic [2:0]          state_reg, state_next;
    logic [CLW-1:0]      clr_reg, clr_next;
    logic [RGW-1:0]      cfg_reg;
    logic [GW-1:0]       g_reg, g_next;
    logic [BW-1:0]       base_reg, base_next;
    logic [WAW-1:0]      waddr_reg, waddr_next;
    logic [BW-1:0]       idx_reg, idx_next;
    logic [CNW-1:0]      cnt_reg, cnt_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;
    logic [STATUS_W-1:0] m_st_reg, m_st_next;

    logic [GW-1:0]       ngroups;
    logic [BW-1:0]       base_end;
    logic [BW-1:0]       free_lim;
    logic [BW-1:0]       word_end;
    scan_res_t           scan;

    always_comb begin
        if (cfg_reg > RGW'(MAX_GROUPS)) begin
            ngroups = GW'(MAX_GROUPS);
        end else begin
            ngroups = GW'(cfg_reg);
        end
    end

    assign base_end = base_reg + BW'(IDS_PER_GROUP);
    assign free_lim = BW'(ngroups) * BW'(IDS_PER_GROUP);
    assign word_end = (BW'(waddr_reg) + BW'(1)) << WSH;

    gbia_word_scan #(
        .BW  (BW),
        .WAW (WAW)
    ) u_scan (
        .word  (map_rd),
        .waddr (waddr_reg),
        .lo    (base_reg),
        .hi    (base_end),
        .res   (scan)
    );

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_allocated_id = m_id_reg;
    assign m_status       = m_st_reg;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        g_next       = g_reg;
        base_next    = base_reg;
        waddr_next   = waddr_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        res_id_next  = res_id_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_id_next    = m_id_reg;
        m_st_next    = m_st_reg;
        map_we       = 1'b0;
        map_wa       = waddr_reg;
        map_wd       = map_rd;
        cnt_we       = 1'b0;
        cnt_wa       = g_reg[GIW-1:0];
        cnt_wd       = cnt_reg;

        case (state_reg)
            S_CLEAR: begin
                map_we = (32'(clr_reg) < MAP_WORDS);
                map_wa = WAW'(clr_reg);
                map_wd = '0;
                cnt_we = (32'(clr_reg) < MAX_GROUPS);
                cnt_wa = GIW'(clr_reg);
                cnt_wd = CNW'(IDS_PER_GROUP);
                if (32'(clr_reg) == CLR_LEN - 1) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + CLW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    g_next      = '0;
                    base_next   = '0;
                    res_id_next = '0;
                    if (s_kind == KIND_ALLOC) begin
                        if (ngroups == '0) begin
                            res_st_next = ST_FULL;
                            state_next  = S_RESP;
                        end else begin
                            state_next = S_ACNT;
                        end
                    end else begin
                        if (s_free_id == '0 || BW'(s_free_id) > free_lim) begin
                            res_st_next = ST_BAD;
                            state_next  = S_RESP;
                        end else begin
                            idx_next   = BW'(s_free_id) - BW'(1);
                            state_next = S_FGRP;
                        end
                    end
                end
            end
            S_ACNT: begin
                if (cnt_rd != '0) begin
                    cnt_next   = cnt_rd;
                    waddr_next = WAW'(base_reg >> WSH);
                    state_next = S_AWORD;
                end else begin
                    g_next    = g_reg + GW'(1);
                    base_next = base_end;
                    if (g_reg + GW'(1) == ngroups) begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                end
            end
            S_AWORD: begin
                if (scan.found) begin
                    map_we      = 1'b1;
                    map_wd      = map_rd | (WORD_W'(1) << scan.bit_idx);
                    cnt_we      = 1'b1;
                    cnt_wd      = cnt_reg - CNW'(1);
                    res_id_next = ID_W'(BW'({waddr_reg, scan.bit_idx}) + BW'(1));
                    res_st_next = ST_DONE;
                    state_next  = S_RESP;
                end else if (word_end >= base_end) begin
                    g_next    = g_reg + GW'(1);
                    base_next = base_end;
                    if (g_reg + GW'(1) == ngroups) begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        state_next = S_ACNT;
                    end
                end else begin
                    waddr_next = waddr_reg + WAW'(1);
                end
            end
            S_FGRP: begin
                if (idx_reg < base_end) begin
                    waddr_next = WAW'(idx_reg >> WSH);
                    state_next = S_FCHK;
                end else begin
                    g_next    = g_reg + GW'(1);
                    base_next = base_end;
                end
            end
            S_FCHK: begin
                state_next = S_RESP;
                if (!map_rd[idx_reg[WSH-1:0]]) begin
                    res_st_next = ST_BAD;
                end else begin
                    map_we      = 1'b1;
                    map_wd      = map_rd & ~(WORD_W'(1) << idx_reg[WSH-1:0]);
                    cnt_we      = 1'b1;
                    cnt_wd      = (cnt_rd < CNW'(IDS_PER_GROUP)) ? cnt_rd + CNW'(1) : cnt_rd;
                    res_st_next = ST_DONE;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_id_next    = res_id_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read addresses follow the next-state values, so read data lines up with the registers
    assign map_ra = waddr_next;
    assign cnt_ra = g_next[GIW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            g_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            g_reg       <= g_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= RGW'(MAX_GROUPS);
        end else if (cfg_we) begin
            cfg_reg <= RGW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        base_reg   <= base_next;
        waddr_reg  <= waddr_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        res_id_reg <= res_id_next;
        res_st_reg <= res_st_next;
        m_id_reg   <= m_id_next;
        m_st_reg   <= m_st_next;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks grouped_bitmap_id_allocator_top against an in-bench predictor of the
// usage bitmap and group free counts. A short table of directed requests is
// followed by random phases under several group limits, with random gaps on
// both sides of the valid/ready channels.
// ----------------------------------------------------------------------------
module tb;
    import gbia_pkg::*;

    localparam int MAX_GROUPS    = 8;
    localparam int IDS_PER_GROUP = 256;
    localparam int TOTAL_IDS     = MAX_GROUPS * IDS_PER_GROUP;
    localparam int SCAN_LAT      = 2 + MAX_GROUPS + TOTAL_IDS / WORD_W;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
    } grant_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] id;
        logic            typed;
        grant_t          want;
    } dir_row_t;

    localparam int N_DIR = 17;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{KIND_ALLOC, 12'd0,    1'b1, '{12'd1, ST_DONE}},
        '{KIND_ALLOC, 12'd4095, 1'b1, '{12'd2, ST_DONE}},
        '{KIND_ALLOC, 12'd0,    1'b1, '{12'd3, ST_DONE}},
        '{KIND_FREE,  12'd0,    1'b1, '{12'd0, ST_BAD}},
        '{KIND_FREE,  12'd4095, 1'b1, '{12'd0, ST_BAD}},
        '{KIND_FREE,  12'd2048, 1'b1, '{12'd0, ST_BAD}},
        '{KIND_FREE,  12'd2,    1'b1, '{12'd0, ST_DONE}},
        '{KIND_FREE,  12'd2,    1'b1, '{12'd0, ST_BAD}},
        '{KIND_ALLOC, 12'd0,    1'b1, '{12'd2, ST_DONE}},
        '{KIND_FREE,  12'd2049, 1'b1, '{12'd0, ST_BAD}},
        '{KIND_FREE,  12'd1,    1'b0, '{12'd0, ST_DONE}},
        '{KIND_FREE,  12'd3,    1'b0, '{12'd0, ST_DONE}},
        '{KIND_ALLOC, 12'h555,  1'b0, '{12'd0, ST_DONE}},
        '{KIND_FREE,  12'h555,  1'b0, '{12'd0, ST_DONE}},
        '{KIND_FREE,  12'hAAA,  1'b1, '{12'd0, ST_BAD}},
        '{KIND_ALLOC, 12'd0,    1'b0, '{12'd0, ST_DONE}},
        '{KIND_FREE,  12'd1,    1'b0, '{12'd0, ST_DONE}}
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_kind    = KIND_ALLOC;
    logic [ID_W-1:0]     s_free_id = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [ID_W-1:0]     m_allocated_id;
    logic [STATUS_W-1:0] m_status;

    grouped_bitmap_id_allocator_top #(
        .MAX_GROUPS    (MAX_GROUPS),
        .IDS_PER_GROUP (IDS_PER_GROUP)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_free_id      (s_free_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_allocated_id (m_allocated_id),
        .m_status       (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predicted allocator state
    bit               id_used [TOTAL_IDS];
    int unsigned      grp_free [MAX_GROUPS];
    logic [CFG_W-1:0] grp_limit;

    grant_t      grant_q [$];
    int unsigned n_in, n_out, n_granted, n_full, n_bad, n_errors;
    int unsigned cycles;
    int unsigned tx_calm, rx_calm;

    function automatic grant_t predict_grant(logic kind, logic [ID_W-1:0] fid);
        grant_t      r;
        int unsigned ng, g, b, idx;
        r.id     = '0;
        r.status = ST_DONE;
        ng = (grp_limit > MAX_GROUPS) ? MAX_GROUPS : grp_limit;
        if (kind == KIND_ALLOC) begin
            for (g = 0; g < ng; g++) begin
                if (grp_free[g] == 0) continue;
                for (b = 0; b < IDS_PER_GROUP; b++) begin
                    idx = g * IDS_PER_GROUP + b;
                    if (!id_used[idx]) begin
                        id_used[idx] = 1'b1;
                        grp_free[g]--;
                        r.id = ID_W'(idx + 1);
                        return r;
                    end
                end
            end
            r.status = ST_FULL;
        end else if (fid == 0 || fid > ng * IDS_PER_GROUP || !id_used[fid - 1]) begin
            r.status = ST_BAD;
        end else begin
            idx = fid - 1;
            id_used[idx] = 1'b0;
            if (grp_free[idx / IDS_PER_GROUP] < IDS_PER_GROUP)
                grp_free[idx / IDS_PER_GROUP]++;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly ids that are in use, the rest edge values and noise
    function automatic logic [ID_W-1:0] pick_free_id();
        int unsigned r, start, k, idx;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            start = $urandom_range(0, TOTAL_IDS - 1);
            for (k = 0; k < TOTAL_IDS; k++) begin
                idx = (start + k) % TOTAL_IDS;
                if (id_used[idx]) return ID_W'(idx + 1);
            end
        end
        if (r < 80) return '0;
        if (r < 85) return '1;
        if (r < 90) return ID_W'(TOTAL_IDS);
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    task automatic send_beat(logic kind, logic [ID_W-1:0] fid, logic typed, grant_t want);
        int unsigned gap;
        grant_t      got;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_free_id <= fid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = predict_grant(kind, fid);
        grant_q.push_back(typed ? want : got);
        n_in++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] limit, int n, int alloc_pct);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grp_limit = limit;
        repeat (n) begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_beat(KIND_ALLOC, ID_W'($urandom), 1'b0, '0);
            else
                send_beat(KIND_FREE, pick_free_id(), 1'b0, '0);
        end
        wait_idle();
    endtask

    initial begin
        forever begin
            int unsigned gap;
            gap = pick_gap(rx_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            n_out++;
            case (m_status)
                ST_DONE: if (m_allocated_id != 0) n_granted++;
                ST_FULL: n_full++;
                default: n_bad++;
            endcase
            if (grant_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result beat: id %0d status %0d",
                             m_allocated_id, m_status);
            end else begin
                want = grant_q.pop_front();
                if (m_allocated_id !== want.id || m_status !== want.status) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("result %0d: expected id %0d status %0d, got id %0d status %0d",
                                 n_out, want.id, want.status, m_allocated_id, m_status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        grp_limit = MAX_GROUPS;
        for (int i = 0; i < TOTAL_IDS; i++) id_used[i] = 1'b0;
        for (int g = 0; g < MAX_GROUPS; g++) grp_free[g] = IDS_PER_GROUP;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_beat(DIR_ROWS[i].kind, DIR_ROWS[i].id, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        wait_idle();

        run_phase(4'd1,  320, 95);   // fill group 0 until full
        run_phase(4'd0,   24, 50);   // no group in use
        run_phase(4'd8,  300, 85);   // skip full group 0, spill onward
        run_phase(4'd1,   60, 40);   // frees above the limit are rejected
        run_phase(4'd15, 200, 55);   // limit saturates
        run_phase(4'd3,  150, 70);
        run_phase(4'd2,   50, 60);
        run_phase(4'd8,   50, 50);

        repeat (SCAN_LAT) @(posedge aclk);
        $display("run: %0d request beats, %0d result beats (%0d granted, %0d full, %0d rejected)",
                 n_in, n_out, n_granted, n_full, n_bad);
        $display("group limits 8,1,0,15,3,2 applied; %0d mismatches", n_errors);
        if (n_errors == 0 && grant_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
